### sv/ewma_convergence_display_smoother_assert.svh
// Assertion macros shared by the smoother RTL.
`ifndef EWMA_CONVERGENCE_DISPLAY_SMOOTHER_ASSERT_SVH
`define EWMA_CONVERGENCE_DISPLAY_SMOOTHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ECDS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ewma smoother: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ECDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ewma smoother: next-cycle check failed");

`endif

### sv/ewma_cds_pkg.sv
package ewma_cds_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int TIME_W           = 32;
    localparam int GAIN_W           = 17;
    localparam int THR_W            = 23;
    localparam int TMO_W            = 16;
    localparam int CFG_W            = 23;
    localparam int CFG_IDX_W        = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EWMA_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_EWMA_GAIN       = GAIN_W'(6554);
    localparam logic [THR_W-1:0]  RST_SETTLE_THRESH   = THR_W'(256);
    localparam logic [TMO_W-1:0]  RST_SETTLE_TIMEOUT  = TMO_W'(500);
    localparam logic [TMO_W-1:0]  RST_CHANGE_TIMEOUT  = TMO_W'(500);
    localparam logic [TMO_W-1:0]  RST_SAMPLE_INTERVAL = TMO_W'(20);

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_WAIT = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [TMO_W-1:0] settle_timeout;
        logic [TMO_W-1:0] change_timeout;
    } t_hold_cfg;

endpackage

### sv/ewma_cds_in_if.sv
interface ewma_cds_in_if import ewma_cds_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic        [TIME_W-1:0]       time_ms;
    logic signed [SAMPLE_WIDTH-1:0] raw_sample;

    modport source (output valid, output time_ms, output raw_sample, input ready);
    modport sink   (input valid, input time_ms, input raw_sample, output ready);
endinterface

### sv/ewma_cds_out_if.sv
interface ewma_cds_out_if import ewma_cds_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic signed [SAMPLE_WIDTH-1:0] display_value;
    logic                           display_valid;

    modport source (output valid, output status, output display_value,
                    output display_valid, input ready);
    modport sink   (input valid, input status, input display_value,
                    input display_valid, output ready);
endinterface

### sv/ewma_convergence_display_smoother.sv
// EWMA display smoother with settling hold. Timestamped Q-format samples come in on i_in;
// one result per sample leaves on o_out. A sample that arrives before the sampling interval
// has passed since the last accepted one returns status WAIT with a blank display. Otherwise
// it updates an exponential moving average (first sample seeds it) and a convergence
// smoother: the display latches a level after the average stays within the threshold for
// the settle timeout, and follows the average after it stays away for the change timeout.
// Throughput is one sample per clock unless o_out stalls; a result passes through the input
// register, then the result register. The rate rests on a combinational state recurrence:
// gain multiply, threshold compare and timer compares all feed the state registers directly
// so the next sample sees the updated average and timers. Configure only while idle.
`include "ewma_convergence_display_smoother_assert.svh"

module ewma_convergence_display_smoother import ewma_cds_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ewma_cds_in_if.sink          i_in,
    ewma_cds_out_if.source       o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);
    localparam int SW = SAMPLE_WIDTH;

    // Configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [TMO_W-1:0]  r_sint;
    t_hold_cfg         r_hold_cfg;

    // Input stage
    logic                 r_in_vld;
    logic [TIME_W-1:0]    r_in_time;
    logic signed [SW-1:0] r_in_sample;

    // Sample-interval gate
    logic              r_armed;
    logic [TIME_W-1:0] r_sst;

    // Result register
    logic                 r_out_vld;
    logic                 r_out_status;
    logic signed [SW-1:0] r_out_value;
    logic                 r_out_dvld;

    logic                 w_out_free, w_fire, w_wait, w_upd;
    logic signed [SW-1:0] w_avg;
    logic                 w_shown_valid;
    logic signed [SW-1:0] w_shown_value;

    // Result register takes a new result when empty or being drained
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_fire     = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_out_free;

    // Reject samples inside the interval; elapsed time wraps modulo 2^32
    assign w_wait = r_armed && ((r_in_time - r_sst) < TIME_W'(r_sint));
    assign w_upd  = w_fire && !w_wait;

    ewma_cds_avg #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_upd),
        .i_sample (r_in_sample),
        .i_gain   (r_gain),
        .o_avg    (w_avg)
    );

    ewma_cds_hold #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_hold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (w_upd),
        .i_now         (r_in_time),
        .i_avg         (w_avg),
        .i_cfg         (r_hold_cfg),
        .o_shown_valid (w_shown_valid),
        .o_shown_value (w_shown_value)
    );

    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain                    <= RST_EWMA_GAIN;
            r_hold_cfg.threshold      <= RST_SETTLE_THRESH;
            r_hold_cfg.settle_timeout <= RST_SETTLE_TIMEOUT;
            r_hold_cfg.change_timeout <= RST_CHANGE_TIMEOUT;
            r_sint                    <= RST_SAMPLE_INTERVAL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_EWMA_GAIN:       r_gain                    <= i_cfg_wdata[GAIN_W-1:0];
                REG_SETTLE_THRESH:   r_hold_cfg.threshold      <= i_cfg_wdata[THR_W-1:0];
                REG_SETTLE_TIMEOUT:  r_hold_cfg.settle_timeout <= i_cfg_wdata[TMO_W-1:0];
                REG_CHANGE_TIMEOUT:  r_hold_cfg.change_timeout <= i_cfg_wdata[TMO_W-1:0];
                REG_SAMPLE_INTERVAL: r_sint                    <= i_cfg_wdata[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: load on transfer, empty once its item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_time   <= i_in.time_ms;
            r_in_sample <= i_in.raw_sample;
        end
    end

    // Arm the interval timer at each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (w_upd) begin
            r_armed <= 1'b1;
        end
        if (w_upd) begin
            r_sst <= r_in_time;
        end
    end

    // Result register; waiting results carry a blank display
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
        if (w_fire) begin
            r_out_status <= w_wait ? STATUS_WAIT : STATUS_OK;
            r_out_dvld   <= !w_wait && w_shown_valid;
            r_out_value  <= (!w_wait && w_shown_valid) ? w_shown_value : '0;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out_status;
    assign o_out.display_value = r_out_value;
    assign o_out.display_valid = r_out_dvld;

    `ECDS_ASSERT_HOLDS(a_wait_blank, i_clk, i_rst_n, r_out_vld && (r_out_status == STATUS_WAIT), !r_out_dvld && (r_out_value == '0))
    `ECDS_ASSERT_NEXT(a_fire_loads, i_clk, i_rst_n, w_fire, r_out_vld)
    `ECDS_ASSERT_HOLDS(a_ok_armed, i_clk, i_rst_n, r_out_vld && (r_out_status == STATUS_OK), r_armed)
endmodule

### sv/ewma_cds_avg.sv
module ewma_cds_avg import ewma_cds_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_upd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic        [GAIN_W-1:0]       i_gain,
    output logic signed [SAMPLE_WIDTH-1:0] o_avg
);
    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = SW + GAIN_W + 2;

    logic signed [SW-1:0]     r_avg;
    logic                     r_avg_vld;

    logic        [GAIN_W-1:0] w_gain;
    logic signed [SW-1:0]     w_base;
    logic signed [SW:0]       w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [SW+1:0]     w_step;
    logic signed [SW+1:0]     w_sum;

    // avg + g*(x - avg)/2^16, rounded half up; seed with the sample itself
    always_comb begin
        w_gain = (i_gain > GAIN_ONE) ? GAIN_ONE : i_gain;
        w_base = r_avg_vld ? r_avg : i_sample;
        w_diff = $signed({i_sample[SW-1], i_sample}) - $signed({w_base[SW-1], w_base});
        w_prod = $signed({1'b0, w_gain}) * w_diff;
        w_rnd  = w_prod + $signed(PROD_W'(32768));
        w_step = w_rnd[SW+17:16];
        w_sum  = $signed({{2{w_base[SW-1]}}, w_base}) + w_step;
        o_avg  = w_sum[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_vld <= 1'b0;
        end else if (i_upd) begin
            r_avg_vld <= 1'b1;
        end
        if (i_upd) begin
            r_avg <= o_avg;
        end
    end
endmodule

### sv/ewma_cds_hold.sv
`include "ewma_convergence_display_smoother_assert.svh"

module ewma_cds_hold import ewma_cds_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_upd,
    input  logic        [TIME_W-1:0]       i_now,
    input  logic signed [SAMPLE_WIDTH-1:0] i_avg,
    input  t_hold_cfg                      i_cfg,
    output logic                           o_shown_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_shown_value
);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int CMP_W = (SW + 1 > THR_W) ? SW + 1 : THR_W;

    logic                 r_pv, r_slv, r_svv, r_cs, r_ss;
    logic signed [SW-1:0] r_prev, r_sl, r_sv;
    logic [TIME_W-1:0]    r_ptime, r_settle_t, r_change_t;

    logic                 n_slv, n_svv, n_cs, n_ss;
    logic signed [SW-1:0] n_sl, n_sv;
    logic [TIME_W-1:0]    n_settle_t, n_change_t;

    logic                 w_cs, w_ss, w_slv, w_svv, w_steady, w_settle_hit, w_change_hit;
    logic [TIME_W-1:0]    w_ptime, w_sst, w_cst;
    logic signed [SW-1:0] w_ref;
    logic signed [SW:0]   w_diff;
    logic        [SW:0]   w_mag;

    always_comb begin
        // Without a previous sample the smoother starts from scratch
        w_cs    = r_pv & r_cs;
        w_ss    = r_pv & r_ss;
        w_slv   = r_pv & r_slv;
        w_svv   = r_pv & r_svv;
        w_ptime = r_pv ? r_ptime : i_now;

        w_ref    = w_slv ? r_sl : r_prev;
        w_diff   = $signed({i_avg[SW-1], i_avg}) - $signed({w_ref[SW-1], w_ref});
        w_mag    = w_diff[SW] ? $unsigned(-w_diff) : $unsigned(w_diff);
        w_steady = r_pv && (CMP_W'(w_mag) < CMP_W'(i_cfg.threshold));

        w_sst = w_ss ? r_settle_t : i_now;
        w_cst = w_cs ? r_change_t : i_now;
        w_settle_hit = ((i_now - w_sst) >= TIME_W'(i_cfg.settle_timeout))
                    && !((w_ptime - w_sst) >= TIME_W'(i_cfg.settle_timeout));
        w_change_hit = (i_now - w_cst) >= TIME_W'(i_cfg.change_timeout);

        n_slv      = w_slv;
        n_sl       = r_sl;
        n_svv      = w_svv;
        n_sv       = r_sv;
        n_cs       = w_cs;
        n_ss       = w_ss;
        n_settle_t = r_settle_t;
        n_change_t = r_change_t;

        if (w_steady) begin
            n_cs       = 1'b0;
            n_ss       = 1'b1;
            n_settle_t = w_sst;
            if (w_settle_hit) begin
                n_sl  = i_avg;
                n_slv = 1'b1;
                n_sv  = i_avg;
                n_svv = 1'b1;
            end
        end else begin
            n_ss       = 1'b0;
            n_cs       = 1'b1;
            n_change_t = w_cst;
            if (w_change_hit) begin
                n_sv  = i_avg;
                n_svv = 1'b1;
                n_slv = 1'b0;
            end
        end

        o_shown_valid = n_svv;
        o_shown_value = n_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_slv <= 1'b0;
            r_svv <= 1'b0;
            r_cs  <= 1'b0;
            r_ss  <= 1'b0;
        end else if (i_upd) begin
            r_pv  <= 1'b1;
            r_slv <= n_slv;
            r_svv <= n_svv;
            r_cs  <= n_cs;
            r_ss  <= n_ss;
        end
        if (i_upd) begin
            r_prev     <= i_avg;
            r_sl       <= n_sl;
            r_sv       <= n_sv;
            r_ptime    <= i_now;
            r_settle_t <= n_settle_t;
            r_change_t <= n_change_t;
        end
    end

    `ECDS_ASSERT_HOLDS(a_level_needs_prev, i_clk, i_rst_n, r_slv, r_pv)
    `ECDS_ASSERT_NEXT(a_shown_sticks, i_clk, i_rst_n, r_svv, r_svv)
    `ECDS_ASSERT_HOLDS(a_timers_exclusive, i_clk, i_rst_n, r_cs, !r_ss)
endmodule
